@@ src/pis_pkg.sv @@
package pis_pkg;

  // Control bits that travel with each particle through the lanes.
  typedef struct packed {
    logic bypass;  // output equals input (pinned, or zero mass)
    logic err;     // moving particle with zero mass
  } pis_ctl_t;

  // Configuration register indexes.
  typedef logic [0:0] pis_reg_idx_t;
  localparam pis_reg_idx_t REG_TIME_STEP = 1'b0;
  localparam pis_reg_idx_t REG_DAMPING   = 1'b1;

endpackage

@@ src/particle_integration_step.sv @@
// Particle integration step. One particle is taken per clock cycle, every
// cycle: busy never rises, and each result appears on the result ports for
// one cycle with done high. Each axis lane holds two pipelined restoring
// dividers, which produce one quotient bit per stage, and the default widths
// give Q16.16 values. The receiver cannot stall the block, so results must
// be taken as they appear. Configuration may be written only while no particle
// is in flight.
module particle_integration_step import pis_pkg::*; #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [WORD_BITS-1:0]  pos_x,
  input  logic signed [WORD_BITS-1:0]  pos_y,
  input  logic signed [WORD_BITS-1:0]  pos_z,
  input  logic signed [WORD_BITS-1:0]  vel_x,
  input  logic signed [WORD_BITS-1:0]  vel_y,
  input  logic signed [WORD_BITS-1:0]  vel_z,
  input  logic signed [WORD_BITS-1:0]  force_x,
  input  logic signed [WORD_BITS-1:0]  force_y,
  input  logic signed [WORD_BITS-1:0]  force_z,
  input  logic [WORD_BITS-1:0]         mass_in,
  input  logic                         pinned,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  pis_reg_idx_t                 cfg_index,
  input  logic [((WORD_BITS > FRACTION_BITS) ? WORD_BITS : FRACTION_BITS + 1)-1:0] cfg_data,
  output logic                         done,
  output logic signed [WORD_BITS-1:0]  new_pos_x,
  output logic signed [WORD_BITS-1:0]  new_pos_y,
  output logic signed [WORD_BITS-1:0]  new_pos_z,
  output logic signed [WORD_BITS-1:0]  new_vel_x,
  output logic signed [WORD_BITS-1:0]  new_vel_y,
  output logic signed [WORD_BITS-1:0]  new_vel_z,
  output logic                         zero_mass_error
);

  localparam int W = WORD_BITS;
  localparam int F = FRACTION_BITS;

  logic [W-1:0] time_step;
  logic [F:0]   damping_factor;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= W'(1092);
      damping_factor <= {1'b1, {F{1'b0}}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_STEP: time_step      <= cfg_data[W-1:0];
        REG_DAMPING:   damping_factor <= cfg_data[F:0];
        default: ;
      endcase
    end
  end

  // Control shared by all three lanes.
  logic     accept;
  pis_ctl_t in_ctl;
  assign accept        = start && !busy;
  assign in_ctl.bypass = pinned || (mass_in == '0);
  assign in_ctl.err    = !pinned && (mass_in == '0);

  logic [W-1:0] pos_in [0:2];
  logic [W-1:0] vel_in [0:2];
  logic [W-1:0] frc_in [0:2];
  logic         l_valid [0:2];
  logic [W-1:0] l_pos [0:2];
  logic [W-1:0] l_vel [0:2];
  pis_ctl_t     l_ctl [0:2];

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign vel_in[0] = vel_x;
  assign vel_in[1] = vel_y;
  assign vel_in[2] = vel_z;
  assign frc_in[0] = force_x;
  assign frc_in[1] = force_y;
  assign frc_in[2] = force_z;

  // One lane per axis.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    pis_lane #(.W(W), .F(F)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (accept),
      .pos       (pos_in[k]),
      .vel       (vel_in[k]),
      .frc       (frc_in[k]),
      .mass      (mass_in),
      .in_ctl    (in_ctl),
      .dt        (time_step),
      .damp      (damping_factor),
      .out_valid (l_valid[k]),
      .out_pos   (l_pos[k]),
      .out_vel   (l_vel[k]),
      .out_ctl   (l_ctl[k])
    );
  end

  // Merge the lanes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= l_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    new_pos_x       <= l_pos[0];
    new_pos_y       <= l_pos[1];
    new_pos_z       <= l_pos[2];
    new_vel_x       <= l_vel[0];
    new_vel_y       <= l_vel[1];
    new_vel_z       <= l_vel[2];
    zero_mass_error <= l_ctl[0].err;
  end

  // The lanes run in lockstep.
  a_lanes_valid: assert property (@(posedge clk) disable iff (rst)
    (l_valid[0] == l_valid[1]) && (l_valid[1] == l_valid[2]))
    else $error("lane valid bits disagree");

  a_lanes_ctl: assert property (@(posedge clk) disable iff (rst)
    l_valid[0] |-> (l_ctl[0] == l_ctl[1]) && (l_ctl[1] == l_ctl[2]))
    else $error("lane control bits disagree");

  // An error result is always a bypassed particle.
  a_err_bypass: assert property (@(posedge clk) disable iff (rst)
    (l_valid[0] && l_ctl[0].err) |-> l_ctl[0].bypass)
    else $error("zero mass error without bypass");

  a_reset_done: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe straight after reset");

endmodule

@@ src/pis_div.sv @@
module pis_div import pis_pkg::*; #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SB = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [W-1:0]       num_mag,
  input  logic               num_neg,
  input  logic [W-1:0]       den,
  input  logic [SB-1:0]      side_in,
  output logic               out_valid,
  output logic [W+F-1:0]     quo,
  output logic               quo_neg,
  output logic [SB-1:0]      side_out
);

  localparam int N = W + F;

  logic [W-1:0]  rem_r  [0:N];
  logic [N-1:0]  num_r  [0:N];
  logic [N-1:0]  q_r    [0:N];
  logic [W-1:0]  den_r  [0:N];
  logic          neg_r  [0:N];
  logic [SB-1:0] side_r [0:N];
  logic [N:0]    vld_r;

  // Valid bits run alongside the quotient stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-1:0], in_valid};
    end
  end

  // Entry stage: the numerator is the magnitude scaled up by the fraction bits.
  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    num_r[0]  <= {num_mag, {F{1'b0}}};
    q_r[0]    <= '0;
    den_r[0]  <= den;
    neg_r[0]  <= num_neg;
    side_r[0] <= side_in;
  end

  // One restoring step per stage, one quotient bit each.
  for (genvar s = 1; s <= N; s++) begin : g_stage
    logic [W:0] shifted;
    logic       ge;
    assign shifted = {rem_r[s-1], num_r[s-1][N-1]};
    assign ge      = shifted >= {1'b0, den_r[s-1]};
    always_ff @(posedge clk) begin
      rem_r[s]  <= ge ? W'(shifted - {1'b0, den_r[s-1]}) : shifted[W-1:0];
      num_r[s]  <= num_r[s-1] << 1;
      q_r[s]    <= {q_r[s-1][N-2:0], ge};
      den_r[s]  <= den_r[s-1];
      neg_r[s]  <= neg_r[s-1];
      side_r[s] <= side_r[s-1];
    end
  end

  assign out_valid = vld_r[N];
  assign quo       = q_r[N];
  assign quo_neg   = neg_r[N];
  assign side_out  = side_r[N];

endmodule

@@ src/pis_lane.sv @@
module pis_lane import pis_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] pos,
  input  logic [W-1:0] vel,
  input  logic [W-1:0] frc,
  input  logic [W-1:0] mass,
  input  pis_ctl_t     in_ctl,
  input  logic [W-1:0] dt,
  input  logic [F:0]   damp,
  output logic         out_valid,
  output logic [W-1:0] out_pos,
  output logic [W-1:0] out_vel,
  output pis_ctl_t     out_ctl
);

  localparam int N  = W + F;
  localparam int XW = (2 * W > N + 1) ? 2 * W : N + 1;
  localparam int CB = $bits(pis_ctl_t);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] a);
    return a[W-1] ? (~a + W'(1)) : a;
  endfunction

  // Saturate a sign and magnitude pair to the signed word range.
  function automatic logic [W-1:0] to_word(input logic neg, input logic [XW-1:0] m);
    if (!neg) begin
      return (m > XW'(WMAX)) ? WMAX : m[W-1:0];
    end
    return (m >= XW'(WMIN)) ? WMIN : (~m[W-1:0] + W'(1));
  endfunction

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? WMIN : WMAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? WMIN : WMAX;
    end
    return s[W-1:0];
  endfunction

  // Acceleration: force over mass.
  logic            d1_valid;
  logic [N-1:0]    d1_q;
  logic            d1_neg;
  logic [CB+2*W-1:0] d1_side;

  pis_div #(.W(W), .F(F), .SB(CB + 2 * W)) u_div_acc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .num_mag   (mag_of(frc)),
    .num_neg   (frc[W-1]),
    .den       (mass),
    .side_in   ({in_ctl, pos, vel}),
    .out_valid (d1_valid),
    .quo       (d1_q),
    .quo_neg   (d1_neg),
    .side_out  (d1_side)
  );

  // Valid bits of the middle stages.
  logic [5:0] vld;
  logic       d2_valid;
  logic [1:0] vld_t;

  pis_ctl_t   ctl  [1:6];
  logic [W-1:0] p_r [1:6];
  logic [W-1:0] v_r [1:6];

  // Stage 1: half acceleration magnitude and velocity magnitude.
  logic [W-1:0] s1_a;
  logic [W-1:0] s1_hm;
  logic         s1_hneg;
  logic [W-1:0] s1_vm;
  logic         s1_vneg;
  assign s1_a = to_word(d1_neg, XW'(d1_q));

  always_ff @(posedge clk) begin
    {ctl[1], p_r[1], v_r[1]} <= d1_side;
    s1_hm   <= mag_of(s1_a) >> 1;
    s1_hneg <= s1_a[W-1];
    s1_vm   <= mag_of(d1_side[W-1:0]);
    s1_vneg <= d1_side[W-1];
  end

  // Stage 2: products with the time step.
  logic [2*W-1:0] s2_ph;
  logic [2*W-1:0] s2_pv;
  logic           s2_hneg;
  logic           s2_vneg;

  always_ff @(posedge clk) begin
    ctl[2]  <= ctl[1];
    p_r[2]  <= p_r[1];
    v_r[2]  <= v_r[1];
    s2_ph   <= s1_hm * dt;
    s2_pv   <= s1_vm * dt;
    s2_hneg <= s1_hneg;
    s2_vneg <= s1_vneg;
  end

  // Stage 3: truncate and saturate both products.
  logic [W-1:0] s3_t1;
  logic [W-1:0] s3_t1m;
  logic         s3_t1neg;
  logic [W-1:0] s3_vdt;
  assign s3_t1 = to_word(s2_hneg, XW'(s2_ph >> F));

  always_ff @(posedge clk) begin
    ctl[3]   <= ctl[2];
    p_r[3]   <= p_r[2];
    v_r[3]   <= v_r[2];
    s3_t1m   <= mag_of(s3_t1);
    s3_t1neg <= s3_t1[W-1];
    s3_vdt   <= to_word(s2_vneg, XW'(s2_pv >> F));
  end

  // Stage 4: second product with the time step.
  logic [2*W-1:0] s4_pt;
  logic           s4_tneg;
  logic [W-1:0]   s4_vdt;

  always_ff @(posedge clk) begin
    ctl[4]  <= ctl[3];
    p_r[4]  <= p_r[3];
    v_r[4]  <= v_r[3];
    s4_pt   <= s3_t1m * dt;
    s4_tneg <= s3_t1neg;
    s4_vdt  <= s3_vdt;
  end

  // Stage 5: acceleration term and first position sum.
  logic [W-1:0] s5_term;
  logic [W-1:0] s5_sum;

  always_ff @(posedge clk) begin
    ctl[5]  <= ctl[4];
    p_r[5]  <= p_r[4];
    v_r[5]  <= v_r[4];
    s5_term <= to_word(s4_tneg, XW'(s4_pt >> F));
    s5_sum  <= sat_add(p_r[4], s4_vdt);
  end

  // Stage 6: new position.
  logic [W-1:0] s6_np;

  always_ff @(posedge clk) begin
    ctl[6] <= ctl[5];
    p_r[6] <= p_r[5];
    v_r[6] <= v_r[5];
    s6_np  <= sat_add(s5_sum, s5_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], d1_valid};
    end
  end

  // Velocity: position change over the time step.
  logic [W-1:0]      s6_diff;
  logic [N-1:0]      d2_q;
  logic              d2_neg;
  logic [CB+3*W-1:0] d2_side;
  assign s6_diff = sat_sub(s6_np, p_r[6]);

  pis_div #(.W(W), .F(F), .SB(CB + 3 * W)) u_div_vel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[5]),
    .num_mag   (mag_of(s6_diff)),
    .num_neg   (s6_diff[W-1]),
    .den       (dt),
    .side_in   ({ctl[6], p_r[6], v_r[6], s6_np}),
    .out_valid (d2_valid),
    .quo       (d2_q),
    .quo_neg   (d2_neg),
    .side_out  (d2_side)
  );

  // Stage 8: saturated quotient as magnitude and sign.
  logic [W-1:0]      s8_vq;
  logic [W-1:0]      s8_vqm;
  logic              s8_neg;
  logic [CB+3*W-1:0] s8_side;
  assign s8_vq = to_word(d2_neg, XW'(d2_q));

  always_ff @(posedge clk) begin
    s8_vqm  <= mag_of(s8_vq);
    s8_neg  <= s8_vq[W-1];
    s8_side <= d2_side;
  end

  // Stage 9: damping product.
  logic [W+F:0]      s9_pd;
  logic              s9_neg;
  logic [CB+3*W-1:0] s9_side;

  always_ff @(posedge clk) begin
    s9_pd   <= s8_vqm * damp;
    s9_neg  <= s8_neg;
    s9_side <= s8_side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_t <= '0;
    end else begin
      vld_t <= {vld_t[0], d2_valid};
    end
  end

  // Final selection: bypassed particles and a zero time step.
  pis_ctl_t     f_ctl;
  logic [W-1:0] f_p;
  logic [W-1:0] f_v;
  logic [W-1:0] f_np;
  assign {f_ctl, f_p, f_v, f_np} = s9_side;

  always_comb begin
    out_ctl = f_ctl;
    if (f_ctl.bypass) begin
      out_pos = f_p;
      out_vel = f_v;
    end else begin
      out_pos = f_np;
      out_vel = (dt == '0) ? '0 : to_word(s9_neg, XW'(s9_pd >> F));
    end
  end

  assign out_valid = vld_t[1];

endmodule

@@ bench/particle_integration_step_tb.sv @@
`timescale 1ns / 100ps

module particle_integration_step_tb;
  import pis_pkg::*;

  typedef logic signed [31:0] word_t;

  typedef struct {
    word_t       p[3];
    word_t       v[3];
    word_t       f[3];
    logic [31:0] mass;
    logic        pin;
  } particle_t;

  typedef struct {
    word_t np[3];
    word_t nv[3];
    logic  err;
  } motion_t;

  typedef struct {
    particle_t part;
    logic      typed;
    motion_t   want;
  } row_t;

  localparam int SETTLE_CYCLES = 130;
  localparam int CYCLE_LIMIT   = 400000;
  localparam word_t WMAX = 32'sh7FFF_FFFF;
  localparam word_t WMIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  word_t pos_x = '0, pos_y = '0, pos_z = '0;
  word_t vel_x = '0, vel_y = '0, vel_z = '0;
  word_t force_x = '0, force_y = '0, force_z = '0;
  logic [31:0] mass_in = '0;
  logic pinned = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  pis_reg_idx_t cfg_index = REG_TIME_STEP;
  logic [31:0] cfg_data = '0;
  logic done;
  word_t new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
  logic zero_mass_error;

  // A typed expectation travels with the request it belongs to.
  logic    req_typed = 1'b0;
  motion_t req_want;

  // Predictor copy of the configuration registers.
  logic [31:0] step_dt = 32'd1092;
  logic [16:0] damp    = 17'd65536;

  motion_t pending[$];
  int errors = 0;
  int results_seen = 0;
  int requests = 0;
  int pinned_count = 0;
  int massless_count = 0;
  int cycles = 0;

  particle_integration_step DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .mass_in(mass_in), .pinned(pinned),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done),
    .new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z),
    .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
    .zero_mass_error(zero_mass_error)
  );

  always #4 clk = ~clk;

  // Magnitude of a signed word, one bit wider so the minimum fits.
  function automatic logic [32:0] magnitude(word_t x);
    logic signed [32:0] e;
    e = x;
    return (e < 0) ? -e : e;
  endfunction

  // Truncated magnitude plus sign back to a saturated word.
  function automatic word_t clamp_mag(logic neg, logic [127:0] m);
    if (!neg) return (m > 128'h7FFF_FFFF) ? WMAX : word_t'(m[31:0]);
    if (m >= 128'h8000_0000) return WMIN;
    return -word_t'(m[31:0]);
  endfunction

  function automatic word_t fx_mul(word_t a, logic [31:0] b);
    logic [127:0] m;
    m = ({95'd0, magnitude(a)} * {96'd0, b}) >> 16;
    return clamp_mag(a < 0, m);
  endfunction

  function automatic word_t fx_div(word_t n, logic [31:0] d);
    logic [127:0] m;
    m = ({95'd0, magnitude(n)} << 16) / {96'd0, d};
    return clamp_mag(n < 0, m);
  endfunction

  function automatic word_t clamp_long(longint s);
    if (s > longint'(WMAX)) return WMAX;
    if (s < longint'(WMIN)) return WMIN;
    return word_t'(s);
  endfunction

  // One integration step for a whole particle.
  function automatic motion_t integrate(particle_t q);
    motion_t r;
    word_t accel, half, drift, np;
    logic [32:0] am;
    for (int k = 0; k < 3; k++) begin
      r.np[k] = q.p[k];
      r.nv[k] = q.v[k];
      if (!q.pin && q.mass != 0) begin
        accel = fx_div(q.f[k], q.mass);
        am = magnitude(accel) >> 1;
        half = (accel < 0) ? -word_t'(am[31:0]) : word_t'(am[31:0]);
        drift = fx_mul(fx_mul(half, step_dt), step_dt);
        np = clamp_long(longint'(q.p[k]) + longint'(fx_mul(q.v[k], step_dt)));
        np = clamp_long(longint'(np) + longint'(drift));
        r.np[k] = np;
        if (step_dt == 0)
          r.nv[k] = '0;
        else
          r.nv[k] = fx_mul(fx_div(clamp_long(longint'(np) - longint'(q.p[k])), step_dt),
                           {15'd0, damp});
      end
    end
    r.err = !q.pin && q.mass == 0;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  // Requests, configuration writes and results, all seen at the clock edge.
  always @(posedge clk) begin
    particle_t q;
    motion_t w, g;
    cycles++;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TIME_STEP) step_dt <= cfg_data;
        else damp <= cfg_data[16:0];
      end
      if (start && !busy) begin
        q.p[0] = pos_x; q.p[1] = pos_y; q.p[2] = pos_z;
        q.v[0] = vel_x; q.v[1] = vel_y; q.v[2] = vel_z;
        q.f[0] = force_x; q.f[1] = force_y; q.f[2] = force_z;
        q.mass = mass_in;
        q.pin = pinned;
        pending.push_back(req_typed ? req_want : integrate(q));
        requests++;
        if (pinned) pinned_count++;
        else if (mass_in == 0) massless_count++;
      end
      if (done) begin
        results_seen++;
        g.np[0] = new_pos_x; g.np[1] = new_pos_y; g.np[2] = new_pos_z;
        g.nv[0] = new_vel_x; g.nv[1] = new_vel_y; g.nv[2] = new_vel_z;
        g.err = zero_mass_error;
        if (pending.size() == 0) begin
          report("unexpected result, new_pos_x", g.np[0], '0);
        end else begin
          w = pending.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (g.np[k] !== w.np[k]) report($sformatf("new_pos[%0d]", k), g.np[k], w.np[k]);
            if (g.nv[k] !== w.nv[k]) report($sformatf("new_vel[%0d]", k), g.nv[k], w.nv[k]);
          end
          if (g.err !== w.err) report("zero_mass_error", g.err, w.err);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending.size());
      $display("particle_integration_step: mismatch");
      $finish;
    end
  end

  function automatic particle_t make_particle(word_t p, word_t v, word_t f,
                                              logic [31:0] m, logic pin);
    particle_t q;
    for (int k = 0; k < 3; k++) begin
      q.p[k] = p; q.v[k] = v; q.f[k] = f;
    end
    q.mass = m;
    q.pin = pin;
    return q;
  endfunction

  // A pass-through result: position and velocity unchanged.
  function automatic motion_t unchanged(particle_t q, logic err);
    motion_t r;
    r.np = q.p;
    r.nv = q.v;
    r.err = err;
    return r;
  endfunction

  // Random field value: full-range, small, or an extreme.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return WMAX;
      1: return WMIN;
      2, 3, 4, 5: return word_t'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t q;
    for (int k = 0; k < 3; k++) begin
      q.p[k] = rand_word(); q.v[k] = rand_word(); q.f[k] = rand_word();
    end
    case ($urandom_range(0, 9))
      0: q.mass = '0;
      1: q.mass = 32'hFFFF_FFFF;
      2, 3, 4: q.mass = $urandom_range(1, 32'h0010_0000);
      default: q.mass = $urandom();
    endcase
    q.pin = ($urandom_range(0, 9) == 0);
    return q;
  endfunction

  // Present one request and hold it until it is taken.
  task automatic send(particle_t q, logic typed, motion_t want);
    start <= 1'b1;
    pos_x <= q.p[0]; pos_y <= q.p[1]; pos_z <= q.p[2];
    vel_x <= q.v[0]; vel_y <= q.v[1]; vel_z <= q.v[2];
    force_x <= q.f[0]; force_y <= q.f[1]; force_z <= q.f[2];
    mass_in <= q.mass;
    pinned <= q.pin;
    req_typed <= typed;
    req_want <= want;
    do @(posedge clk); while (busy);
  endtask

  // Present one write and hold it until it is taken; the caller drops valid.
  task automatic write_reg(pis_reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Let every request in flight come back before touching the registers.
  task automatic drain();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_burst_run(int count);
    int left, gap;
    motion_t none;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send(rand_particle(), 1'b0, none);
      left--;
    end
  endtask

  row_t rows[$];
  logic [31:0] dt_set[6] = '{32'd1092, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd65536, 32'd0};
  logic [31:0] dp_set[6] = '{32'd65536, 32'd0, 32'd65536, 32'd131071, 32'd32768, 32'd0};

  initial begin
    row_t r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: pass-through cases typed in, the rest predicted.
    r.typed = 1'b1;
    r.part = make_particle(WMAX, WMIN, WMAX, 32'd0, 1'b1);
    r.want = unchanged(r.part, 1'b0); rows.push_back(r);
    r.part = make_particle(WMIN, WMAX, WMIN, 32'hFFFF_FFFF, 1'b1);
    r.want = unchanged(r.part, 1'b0); rows.push_back(r);
    r.part = make_particle(WMAX, WMAX, WMAX, 32'd0, 1'b0);
    r.want = unchanged(r.part, 1'b1); rows.push_back(r);
    r.part = make_particle(WMIN, WMIN, WMIN, 32'd0, 1'b0);
    r.want = unchanged(r.part, 1'b1); rows.push_back(r);
    r.part = make_particle('0, '0, '0, 32'd65536, 1'b0);
    r.want = unchanged(r.part, 1'b0); rows.push_back(r);
    r.typed = 1'b0;
    r.part = make_particle('0, '0, WMAX, 32'd1, 1'b0); rows.push_back(r);
    r.part = make_particle('0, '0, WMIN, 32'd1, 1'b0); rows.push_back(r);
    r.part = make_particle(WMAX, WMAX, WMAX, 32'd1, 1'b0); rows.push_back(r);
    r.part = make_particle(WMIN, WMIN, WMIN, 32'd1, 1'b0); rows.push_back(r);
    r.part = make_particle(WMAX, WMIN, WMAX, 32'hFFFF_FFFF, 1'b0); rows.push_back(r);
    r.part = make_particle(WMIN, WMAX, WMIN, 32'hFFFF_FFFF, 1'b0); rows.push_back(r);
    r.part = make_particle(32'sh0001_0000, 32'sh0002_0000, 32'shFFFF_0000, 32'd65536, 1'b0);
    rows.push_back(r);
    r.part = make_particle(-32'sd1, 32'sd1, -32'sd3, 32'd2, 1'b0); rows.push_back(r);
    r.part = make_particle(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'h8000_0000, 1'b0);
    rows.push_back(r);
    foreach (rows[i]) send(rows[i].part, rows[i].typed, rows[i].want);
    req_typed <= 1'b0;

    // Configuration settings, the extremes among them, each with a random run.
    foreach (dt_set[s]) begin
      drain();
      write_reg(REG_TIME_STEP, (s == 5) ? $urandom() : dt_set[s]);
      write_reg(REG_DAMPING, (s == 5) ? $urandom_range(0, 131071) : dp_set[s]);
      cfg_valid <= 1'b0;
      @(posedge clk);
      random_burst_run(250);
    end

    drain();
    $display("%0d requests over six register settings, %0d pinned, %0d with zero mass",
             requests, pinned_count, massless_count);
    $display("%0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0)
      $display("particle_integration_step: match");
    else
      $display("particle_integration_step: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
src/pis_pkg.sv
src/pis_div.sv
src/pis_lane.sv
src/particle_integration_step.sv
bench/particle_integration_step_tb.sv
